// File: design/awg_pkg.sv
// Shared types, register map, wave codes and the sine table entry function
// for the audio waveform generator. Depends on nothing.
`timescale 1ns / 1ps

package awg_pkg;

   // Register map: word index is paddr[3:2]
   localparam int CSR_ADDR_W = 4;

   localparam logic [1:0] REG_WAVE_TYPE  = 2'd0;
   localparam logic [1:0] REG_VOLUME     = 2'd1;
   localparam logic [1:0] REG_PHASE_STEP = 2'd2;
   localparam logic [1:0] REG_PERIOD     = 2'd3;

   localparam logic [2:0] WAVE_SILENCE  = 3'd0;
   localparam logic [2:0] WAVE_SINE     = 3'd1;
   localparam logic [2:0] WAVE_SQUARE   = 3'd2;
   localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
   localparam logic [2:0] WAVE_SAWTOOTH = 3'd4;
   localparam logic [2:0] WAVE_NOISE    = 3'd5;

   localparam logic [16:0] VOLUME_RESET     = 17'd65536;
   localparam logic [16:0] VOL_FULL         = 17'd65536;
   localparam logic [31:0] PHASE_STEP_RESET = 32'd97391549;
   localparam logic [15:0] PERIOD_RESET     = 16'd44;
   localparam logic [15:0] PERIOD_MIN       = 16'd4;

   localparam logic [31:0] LFSR_MASK  = 32'h8020_0003;
   localparam logic [31:0] NOISE_SEED = 32'h0000_0001;
   localparam logic [15:0] ROUND_Q16  = 16'h8000;
   localparam logic [29:0] ROUND_Q30  = 30'h2000_0000;

   // Ramp divisor is twice (ramp length - 1), which always fits 17 bits
   localparam int DIVISOR_W = 17;

   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] ONE_Q30 = 64'd1073741824;

   typedef struct packed {
      logic [2:0]  wave_type;
      logic [16:0] volume;
      logic [31:0] phase_step;
      logic [15:0] period;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SAW_CHECK,
      ST_SAW_MOD,
      ST_TRI_CHECK,
      ST_TRI_MOD,
      ST_SINE_READ,
      ST_SINE_MUL,
      ST_NOISE_MUL,
      ST_RAMP_MUL,
      ST_RAMP_DIV,
      ST_RAMP_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic saw_direct;
      logic saw_mod_start;
      logic saw_mod_take;
      logic tri_direct;
      logic tri_mod_start;
      logic tri_mod_take;
      logic rom_read;
      logic sine_mul;
      logic noise_mul;
      logic ramp_mul;
      logic ramp_div_start;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic       saw_in_range;
      logic       tri_in_range;
      logic       div_busy;
      logic       out_free;
      logic [2:0] wave_type;
   } dp_status_type;

   // One Q30 sine value for a phase t in 2^-32 turns: fold to the first
   // quadrant, then Taylor series to x^13. Evaluated at elaboration only.
   function automatic logic signed [31:0] sine_entry(input logic [63:0] t_in);
      logic [63:0]        t;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic               neg;
      neg = (t_in >= 64'h8000_0000);
      t = t_in & 64'h7FFF_FFFF;
      if (t > ONE_Q30) begin
         t = 64'h8000_0000 - t;
      end
      x = (t * PI_Q30) >> 31;
      x2 = (x * x) >> 30;
      term = x;
      sum = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum = sum + $signed(term);
      if (sum < 0) begin
         sum = '0;
      end
      if (sum > $signed(ONE_Q30)) begin
         sum = $signed(ONE_Q30);
      end
      return neg ? 32'(-sum) : 32'(sum);
   endfunction

endpackage

// File: design/awg_if.sv
// Handshake channels of the waveform generator: request and result words.
// Depends on nothing.
`timescale 1ns / 1ps

interface awg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface awg_rsp_if #(parameter int SAMPLE_WIDTH = 32);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

// File: design/awg_csr.sv
// APB-style configuration registers of the waveform generator.
// Depends on awg_pkg.
`timescale 1ns / 1ps

module awg_csr import awg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [2:0]  wave_type_ff, wave_type_in;
   logic [16:0] volume_ff, volume_in;
   logic [31:0] phase_step_ff, phase_step_in;
   logic [15:0] period_ff, period_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      wave_type_in  = wave_type_ff;
      volume_in     = volume_ff;
      phase_step_in = phase_step_ff;
      period_in     = period_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_WAVE_TYPE:  wave_type_in  = pwdata[2:0];
            REG_VOLUME:     volume_in     = pwdata[16:0];
            REG_PHASE_STEP: phase_step_in = pwdata;
            REG_PERIOD:     period_in     = pwdata[15:0];
            default:        period_in     = period_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_type_ff  <= WAVE_SILENCE;
         volume_ff     <= VOLUME_RESET;
         phase_step_ff <= PHASE_STEP_RESET;
         period_ff     <= PERIOD_RESET;
      end else begin
         wave_type_ff  <= wave_type_in;
         volume_ff     <= volume_in;
         phase_step_ff <= phase_step_in;
         period_ff     <= period_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_WAVE_TYPE:  prdata = 32'(wave_type_ff);
         REG_VOLUME:     prdata = 32'(volume_ff);
         REG_PHASE_STEP: prdata = phase_step_ff;
         REG_PERIOD:     prdata = 32'(period_ff);
         default:        prdata = '0;
      endcase
   end

   assign cfg.wave_type  = wave_type_ff;
   assign cfg.volume     = volume_ff;
   assign cfg.phase_step = phase_step_ff;
   assign cfg.period     = period_ff;

endmodule

// File: design/awg_divider.sv
// Restoring divider, one quotient bit a cycle, shared by the position
// reductions and the ramp slope. Depends on nothing.
`timescale 1ns / 1ps

module awg_divider #(
   parameter int QUO_W = 32,
   parameter int DIV_W = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] rem_init,
   input  logic [QUO_W-1:0] quo_init,
   input  logic [DIV_W-1:0] divisor,
   output logic             busy,
   output logic [QUO_W-1:0] quotient,
   output logic [DIV_W-1:0] remainder
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] div_ff, div_in;
   logic [DIV_W:0]   partial;
   logic [DIV_W:0]   diff;
   logic             take;

   // Remainder stays below the divisor, so the trial value is under twice it
   assign partial = {rem_ff, quo_ff[QUO_W-1]};
   assign take    = (partial >= {1'b0, div_ff});
   assign diff    = partial - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QUO_W);
         rem_in  = rem_init;
         quo_in  = quo_init;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = take ? diff[DIV_W-1:0] : partial[DIV_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], take};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: design/awg_datapath.sv
// Datapath of the waveform generator: phase, ramp and noise state, sine
// table, product register, divider and the result word. Depends on awg_pkg
// and awg_divider.
`timescale 1ns / 1ps

module awg_datapath import awg_pkg::*; #(
   parameter int SINE_DEPTH   = 1024,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cfg_type                        cfg,
   input  dp_cmd_type                     cmd,
   output dp_status_type                  status,
   input  logic                           req_restart,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample
);

   localparam int SW     = SAMPLE_WIDTH;
   localparam int IDX_W  = $clog2(SINE_DEPTH);
   localparam int VOL_W  = SW + 16;
   localparam int PROD_W = SW + 31;
   localparam int NUM_W  = SW + 18;

   // Sine table, folded to constants at elaboration
   logic signed [31:0] sine_rom [SINE_DEPTH];

   for (genvar g = 0; g < SINE_DEPTH; g++) begin : g_rom
      localparam logic [63:0] PhaseT = (64'(g) << 32) / SINE_DEPTH;
      assign sine_rom[g] = sine_entry(PhaseT);
   end

   logic [16:0]       vol_sat;
   logic [VOL_W-1:0]  fs_vol;
   logic [VOL_W-1:0]  amp_max_sum;
   logic [VOL_W-1:0]  amp_min_sum;
   logic [SW-1:0]     amp_max_w, amp_mag_w, span_w;
   logic [SW-1:0]     amp_max_ff, amp_mag_ff, span_ff;
   logic [SW-1:0]     amp_min_w;
   logic [15:0]       p_eff;
   logic [14:0]       h_eff;
   logic [15:0]       saw_div;
   logic [14:0]       tri_div;

   logic [31:0]       phase_acc_ff, phase_acc_in;
   logic [15:0]       saw_pos_ff, saw_pos_in;
   logic [14:0]       tri_pos_ff, tri_pos_in;
   logic [31:0]       noise_ff, noise_in;
   logic [15:0]       saw_n_ff, saw_n_in;
   logic [14:0]       tri_n_ff, tri_n_in;
   logic [PROD_W-1:0] mul_ff, mul_in;
   logic signed [31:0] rom_q_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0] rsp_sample_ff, rsp_sample_in;

   logic [31+IDX_W:0] idx_prod;
   logic [IDX_W-1:0]  sine_idx;
   logic [31:0]       rom_abs;
   logic [30:0]       sine_mag;
   logic [SW+30:0]    sine_prod;
   logic signed [SW-1:0]  noise_val;
   logic signed [SW+17:0] noise_prod;
   logic [15:0]       ramp_n;
   logic [15:0]       ramp_d;
   logic [SW+15:0]    ramp_prod;
   logic [NUM_W-1:0]  ramp_num;
   logic [PROD_W-1:0] sine_sum;
   logic [PROD_W-1:0] noise_sum;
   logic [SW-1:0]     sine_r;
   logic [SW-1:0]     sample_w;
   logic              low_half;
   logic              is_tri;

   logic                 div_start;
   logic [DIVISOR_W-1:0] div_rem_init;
   logic [SW-1:0]        div_quo_init;
   logic [DIVISOR_W-1:0] div_divisor;
   logic                 div_busy;
   logic [SW-1:0]        div_quo;
   logic [DIVISOR_W-1:0] div_rem;

   // Amplitudes from the saturated volume
   assign vol_sat     = (cfg.volume > VOL_FULL) ? VOL_FULL : cfg.volume;
   assign fs_vol      = VOL_W'(vol_sat) << (SW - 1);
   assign amp_max_sum = fs_vol - VOL_W'(vol_sat) + VOL_W'(ROUND_Q16);
   assign amp_min_sum = fs_vol + VOL_W'(ROUND_Q16);
   assign amp_max_w   = amp_max_sum[16 +: SW];
   assign amp_mag_w   = amp_min_sum[16 +: SW];
   assign span_w      = amp_max_w + amp_mag_w;
   assign amp_min_w   = '0 - amp_mag_ff;

   assign p_eff   = (cfg.period < PERIOD_MIN) ? PERIOD_MIN : cfg.period;
   assign h_eff   = p_eff[15:1];
   assign saw_div = p_eff - 16'd1;
   assign tri_div = h_eff - 15'd1;

   assign is_tri   = (cfg.wave_type == WAVE_TRIANGLE);
   assign low_half = phase_acc_ff[31] ^ phase_acc_ff[30];

   // Multiplier operands
   assign idx_prod   = (32 + IDX_W)'(phase_acc_ff) * (32 + IDX_W)'(SINE_DEPTH);
   assign sine_idx   = idx_prod[32 +: IDX_W];
   assign rom_abs    = rom_q_ff[31] ? 32'(-rom_q_ff) : rom_q_ff;
   assign sine_mag   = rom_abs[30:0];
   assign sine_prod  = amp_max_ff * sine_mag;
   assign noise_val  = $signed(noise_ff[31 -: SW]);
   assign noise_prod = noise_val * $signed({1'b0, vol_sat});
   assign ramp_n     = is_tri ? 16'(tri_n_ff) : saw_n_ff;
   assign ramp_d     = is_tri ? 16'(tri_div) : saw_div;
   assign ramp_prod  = ramp_n * span_ff;

   // Rounded ramp value: (2*n*span + d) / (2*d)
   assign ramp_num = (NUM_W'(mul_ff[SW+15:0]) << 1) + NUM_W'(ramp_d);

   assign div_start = cmd.saw_mod_start | cmd.tri_mod_start | cmd.ramp_div_start;

   always_comb begin
      div_rem_init = '0;
      div_quo_init = SW'(saw_pos_ff);
      div_divisor  = DIVISOR_W'(p_eff);
      if (cmd.tri_mod_start) begin
         div_quo_init = SW'(tri_pos_ff);
         div_divisor  = DIVISOR_W'(h_eff);
      end else if (cmd.ramp_div_start) begin
         div_rem_init = ramp_num[SW +: DIVISOR_W];
         div_quo_init = ramp_num[SW-1:0];
         div_divisor  = {ramp_d, 1'b0};
      end
   end

   awg_divider #(
      .QUO_W (SW),
      .DIV_W (DIVISOR_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .rem_init  (div_rem_init),
      .quo_init  (div_quo_init),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign sine_sum  = mul_ff + PROD_W'(ROUND_Q30);
   assign noise_sum = mul_ff + PROD_W'(ROUND_Q16);
   assign sine_r    = sine_sum[30 +: SW];

   always_comb begin
      case (cfg.wave_type)
         WAVE_SINE:     sample_w = rom_q_ff[31] ? ('0 - sine_r) : sine_r;
         WAVE_SQUARE:   sample_w = low_half ? amp_min_w : amp_max_ff;
         WAVE_TRIANGLE: sample_w = low_half ? (amp_max_ff - div_quo) : (amp_min_w + div_quo);
         WAVE_SAWTOOTH: sample_w = amp_min_w + div_quo;
         WAVE_NOISE:    sample_w = noise_sum[16 +: SW];
         default:       sample_w = '0;
      endcase
   end

   always_comb begin
      phase_acc_in  = phase_acc_ff;
      saw_pos_in    = saw_pos_ff;
      tri_pos_in    = tri_pos_ff;
      noise_in      = noise_ff;
      saw_n_in      = saw_n_ff;
      tri_n_in      = tri_n_ff;
      mul_in        = mul_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      if (cmd.load && req_restart) begin
         phase_acc_in = '0;
         saw_pos_in   = '0;
         tri_pos_in   = '0;
      end
      if (cmd.saw_direct) begin
         saw_n_in = saw_pos_ff;
      end else if (cmd.saw_mod_take) begin
         saw_n_in = div_rem[15:0];
      end
      if (cmd.tri_direct) begin
         tri_n_in = tri_pos_ff;
      end else if (cmd.tri_mod_take) begin
         tri_n_in = div_rem[14:0];
      end
      if (cmd.sine_mul) begin
         mul_in = PROD_W'(sine_prod);
      end else if (cmd.noise_mul) begin
         mul_in = PROD_W'(noise_prod);
      end else if (cmd.ramp_mul) begin
         mul_in = PROD_W'(ramp_prod);
      end
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = $signed(sample_w);
         phase_acc_in  = phase_acc_ff + cfg.phase_step;
         saw_pos_in    = (saw_n_ff == saw_div) ? '0 : saw_n_ff + 16'd1;
         tri_pos_in    = (tri_n_ff == tri_div) ? '0 : tri_n_ff + 15'd1;
         noise_in      = noise_ff[0] ? ((noise_ff >> 1) ^ LFSR_MASK) : (noise_ff >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff <= '0;
         saw_pos_ff   <= '0;
         tri_pos_ff   <= '0;
         noise_ff     <= NOISE_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_acc_ff <= phase_acc_in;
         saw_pos_ff   <= saw_pos_in;
         tri_pos_ff   <= tri_pos_in;
         noise_ff     <= noise_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      saw_n_ff      <= saw_n_in;
      tri_n_ff      <= tri_n_in;
      mul_ff        <= mul_in;
      rsp_sample_ff <= rsp_sample_in;
      if (cmd.load) begin
         amp_max_ff <= amp_max_w;
         amp_mag_ff <= amp_mag_w;
         span_ff    <= span_w;
      end
      if (cmd.rom_read) begin
         rom_q_ff <= sine_rom[sine_idx];
      end
   end

   assign status.saw_in_range = (saw_pos_ff < p_eff);
   assign status.tri_in_range = (tri_pos_ff < h_eff);
   assign status.div_busy     = div_busy;
   assign status.out_free     = !rsp_valid_ff || rsp_ready;
   assign status.wave_type    = cfg.wave_type;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

endmodule

// File: design/awg_ctrl.sv
// Sequencer of the waveform generator: steps the datapath through one
// sample word at a time. Depends on awg_pkg.
`timescale 1ns / 1ps

module awg_ctrl import awg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   state_type wave_state;

   // Pick the wave-specific step once both ramp positions are reduced
   always_comb begin
      case (status.wave_type)
         WAVE_SINE:     wave_state = ST_SINE_READ;
         WAVE_NOISE:    wave_state = ST_NOISE_MUL;
         WAVE_TRIANGLE: wave_state = ST_RAMP_MUL;
         WAVE_SAWTOOTH: wave_state = ST_RAMP_MUL;
         default:       wave_state = ST_EMIT;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SAW_CHECK;
            end
         end
         ST_SAW_CHECK: begin
            state_in = status.saw_in_range ? ST_TRI_CHECK : ST_SAW_MOD;
         end
         ST_SAW_MOD: begin
            if (!status.div_busy) begin
               state_in = ST_TRI_CHECK;
            end
         end
         ST_TRI_CHECK: begin
            state_in = status.tri_in_range ? wave_state : ST_TRI_MOD;
         end
         ST_TRI_MOD: begin
            if (!status.div_busy) begin
               state_in = wave_state;
            end
         end
         ST_SINE_READ: state_in = ST_SINE_MUL;
         ST_SINE_MUL:  state_in = ST_EMIT;
         ST_NOISE_MUL: state_in = ST_EMIT;
         ST_RAMP_MUL:  state_in = ST_RAMP_DIV;
         ST_RAMP_DIV:  state_in = ST_RAMP_WAIT;
         ST_RAMP_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SAW_CHECK: begin
            cmd.saw_direct    = status.saw_in_range;
            cmd.saw_mod_start = !status.saw_in_range;
         end
         ST_SAW_MOD:   cmd.saw_mod_take = !status.div_busy;
         ST_TRI_CHECK: begin
            cmd.tri_direct    = status.tri_in_range;
            cmd.tri_mod_start = !status.tri_in_range;
         end
         ST_TRI_MOD:   cmd.tri_mod_take = !status.div_busy;
         ST_SINE_READ: cmd.rom_read = 1'b1;
         ST_SINE_MUL:  cmd.sine_mul = 1'b1;
         ST_NOISE_MUL: cmd.noise_mul = 1'b1;
         ST_RAMP_MUL:  cmd.ramp_mul = 1'b1;
         ST_RAMP_DIV:  cmd.ramp_div_start = 1'b1;
         ST_EMIT:      cmd.emit = status.out_free;
         default:      cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/audio_waveform_generator_top.sv
// Audio waveform generator: one sample word per request word. The sequencer
// reduces each ramp position (on the divider if left at or above a new
// period), then runs the wave step: table read and multiply for sine, multiply
// for noise, multiply and one-bit-a-cycle divide for triangle and sawtooth.
// A new word is accepted in the same cycle as the result turns valid.
// Reset clears sequencer and generator state; registers default.
`timescale 1ns / 1ps

module audio_waveform_generator_top import awg_pkg::*; #(
   parameter int SINE_DEPTH   = 1024,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   awg_req_if.sink               req_ch,
   awg_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // Datapath config; user keeps it written only while idle; block won't check
   cfg_type       cfg;
   // Command and status between the sequencer and the datapath
   dp_cmd_type    cmd;
   dp_status_type status;

   logic                           rsp_valid;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample;

   // Register bank: wave type, volume, phase step and period
   awg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Sequencer: accepts a request word only from its idle state, then walks
   // position reduction, the wave-specific step and the result hand-off
   awg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: the result register decouples the sink, so a fresh request
   // word can be taken while the previous sample still waits there
   awg_datapath #(
      .SINE_DEPTH   (SINE_DEPTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .status      (status),
      .req_restart (req_ch.restart),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_sample  (rsp_sample)
   );

   // Drive the result channel straight from the result register
   assign rsp_ch.valid  = rsp_valid;
   assign rsp_ch.sample = rsp_sample;

endmodule
